// ----- rtl/psm_pkg.sv -----
// psm_pkg: shared types, codes and constants of the polyphonic sample mixer.
// No dependencies; imported by every rtl file of the block.

package psm_pkg;

    localparam int DEF_NUM_VOICES   = 16;
    localparam int DEF_NUM_SOUNDS   = 8;
    localparam int DEF_SAMPLE_DEPTH = 65536;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_PLAY   = 2'd1;
    localparam logic [1:0] OP_WRSAMP = 2'd2;
    localparam logic [1:0] OP_WRDESC = 2'd3;

    localparam logic [16:0] UNITY_GAIN = 17'h10000;

    localparam logic signed [15:0] MIX_MAX = 16'sh7fff;
    localparam logic signed [15:0] MIX_MIN = 16'sh8000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic               sound_ok;
        logic [2:0]         sound_id;
        logic [16:0]        gain;
        logic [15:0]        address;
        logic signed [15:0] sample;
        logic [16:0]        length;
    } cmd_t;

    function automatic logic [16:0] clamp_gain(input logic [16:0] g);
        return (g > UNITY_GAIN) ? UNITY_GAIN : g;
    endfunction

endpackage

// ----- rtl/psm_front.sv -----
// psm_front: input item acceptance, decode and a short command queue.
// Depends on psm_pkg.

module psm_front import psm_pkg::*;
#(
    parameter int NUM_SOUNDS = DEF_NUM_SOUNDS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [2:0]         sound_id,
    input  logic [16:0]        play_volume,
    input  logic [15:0]        address,
    input  logic signed [15:0] sample_value,
    input  logic [16:0]        sound_length,
    output logic               q_valid,
    output cmd_t               q_cmd,
    input  logic               q_pop
);

    localparam logic [6:0] NSND = 7'(NUM_SOUNDS);

    cmd_t              qmem [QUEUE_DEPTH];
    cmd_t              in_cmd;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;

    always_comb
    begin
        in_cmd.opcode   = opcode;
        in_cmd.sound_ok = ({4'b0, sound_id} < NSND);
        in_cmd.sound_id = sound_id;
        in_cmd.gain     = clamp_gain(play_volume);
        in_cmd.address  = address;
        in_cmd.sample   = sample_value;
        in_cmd.length   = sound_length;
    end

    assign in_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = qmem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qmem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/psm_back.sv -----
// psm_back: command execution - voice table, sample and descriptor memories,
// the per-tick voice walk with its multiply/accumulate pipe, and the result register.
// Depends on psm_pkg.

module psm_back import psm_pkg::*;
#(
    parameter int NUM_VOICES   = DEF_NUM_VOICES,
    parameter int NUM_SOUNDS   = DEF_NUM_SOUNDS,
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    input  logic               cfg_we,
    input  logic [16:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] mixed_sample,
    output logic               saturated
);

    localparam int VC_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CNT_W  = $clog2(NUM_VOICES + 1);
    localparam int SND_W  = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int P1_W   = 34;
    localparam int P2_W   = 52;
    localparam int ACC_W  = P2_W + VC_W;
    localparam int QW     = ACC_W - 32;

    // ceil(2^32 / depth): exact floor quotient for any 16-bit address
    localparam logic [22:0] RECIP =
        23'(((64'd1 << 32) + 64'(SAMPLE_DEPTH) - 64'd1) / 64'(SAMPLE_DEPTH));
    localparam logic [31:0]       DEPTH_32  = 32'(SAMPLE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SAMPLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  NV_CNT    = CNT_W'(NUM_VOICES);
    localparam logic [ACC_W-1:0]  RND_HALF  = ACC_W'(64'h8000_0000);
    localparam logic signed [QW-1:0] Q_MAX  = QW'(32767);
    localparam logic signed [QW-1:0] Q_MIN  = QW'(-32768);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PLAY  = 3'd1;
    localparam logic [2:0] ST_REM   = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_TICK  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    cmd_t       cmd_reg;
    logic [16:0] master_reg;

    // voice table
    logic [ADDR_W-1:0] vaddr_mem [NUM_VOICES];
    logic [16:0]       vcur_mem  [NUM_VOICES];
    logic [16:0]       vend_mem  [NUM_VOICES];
    logic [16:0]       vgain_mem [NUM_VOICES];
    logic [ADDR_W-1:0] vrd_addr_reg;
    logic [16:0]       vrd_cur_reg;
    logic [16:0]       vrd_end_reg;
    logic [16:0]       vrd_gain_reg;
    logic              vm_we;
    logic [VC_W-1:0]   vm_waddr;
    logic [ADDR_W-1:0] vm_waddr_next_addr;
    logic [16:0]       vm_wcur;
    logic [16:0]       vm_wend;
    logic [16:0]       vm_wgain;
    logic [VC_W-1:0]   vm_raddr;
    logic [NUM_VOICES-1:0] active_reg;

    // sample memory
    logic [15:0]       smem [SAMPLE_DEPTH];
    logic [15:0]       srd_reg;
    logic              sm_we;

    // descriptor table
    logic [ADDR_W-1:0]     dstart_mem [NUM_SOUNDS];
    logic [16:0]           dlen_mem   [NUM_SOUNDS];
    logic [NUM_SOUNDS-1:0] dvld_reg;
    logic [ADDR_W-1:0]     drd_start_reg;
    logic [16:0]           drd_len_reg;
    logic                  drd_vld_reg;
    logic [SND_W-1:0]      q_sidx;
    logic [SND_W-1:0]      c_sidx;
    logic [6:0]            q_id_ext;
    logic [6:0]            c_id_ext;
    logic                  dm_we;

    // address reduction
    logic [ADDR_W-1:0] rem_reg;
    logic [15:0]       rem_x_reg;
    logic [6:0]        rem_quo_reg;
    logic              rem_cnt_reg;
    logic [38:0]       rem_prod;
    logic [31:0]       rem_diff;

    // tick pipe
    logic [CNT_W-1:0]        iss_cnt_reg;
    logic                    p1_vld_reg;
    logic [VC_W-1:0]         p1_idx_reg;
    logic                    p2_vld_reg;
    logic [16:0]             p2_gain_reg;
    logic                    p3_vld_reg;
    logic signed [P1_W-1:0]  prod1_reg;
    logic                    p4_vld_reg;
    logic signed [P2_W-1:0]  prod2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    p1_act;
    logic                    p1_play;
    logic                    tick_issue;
    logic                    tick_done;

    logic                    free_found;
    logic [VC_W-1:0]         free_idx;
    logic                    play_go;

    logic [ACC_W-1:0]        rnd;
    logic signed [QW-1:0]    qv;
    logic                    q_hi;
    logic                    q_lo;
    logic                    fin_go;
    logic                    out_valid_reg;
    logic signed [15:0]      mixed_reg;
    logic                    sat_reg;

    assign q_id_ext = {4'b0, q_cmd.sound_id};
    assign c_id_ext = {4'b0, cmd_reg.sound_id};
    assign q_sidx   = q_id_ext[SND_W-1:0];
    assign c_sidx   = c_id_ext[SND_W-1:0];

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VC_W'(i);
            end
        end
    end

    assign play_go = (state_reg == ST_PLAY) && cmd_reg.sound_ok && drd_vld_reg
                     && (drd_len_reg != '0) && free_found;

    assign tick_issue = (state_reg == ST_TICK) && (iss_cnt_reg != NV_CNT);
    assign tick_done  = (state_reg == ST_TICK) && (iss_cnt_reg == NV_CNT) && !p1_vld_reg
                        && !p2_vld_reg && !p3_vld_reg && !p4_vld_reg;
    assign vm_raddr   = iss_cnt_reg[VC_W-1:0];

    assign p1_act  = p1_vld_reg && active_reg[p1_idx_reg];
    assign p1_play = p1_act && (vrd_cur_reg < vrd_end_reg);

    assign vm_waddr_next_addr = (vrd_addr_reg == LAST_ADDR) ? '0 : vrd_addr_reg + 1'b1;

    always_comb
    begin
        if (state_reg == ST_PLAY)
        begin
            vm_we    = play_go;
            vm_waddr = free_idx;
        end
        else
        begin
            vm_we    = p1_play;
            vm_waddr = p1_idx_reg;
        end
    end

    assign vm_wcur  = (state_reg == ST_PLAY) ? 17'd0 : vrd_cur_reg + 1'b1;
    assign vm_wend  = (state_reg == ST_PLAY) ? drd_len_reg : vrd_end_reg;
    assign vm_wgain = (state_reg == ST_PLAY) ? cmd_reg.gain : vrd_gain_reg;

    assign rem_prod = 39'(rem_x_reg) * 39'(RECIP);
    assign rem_diff = 32'(rem_x_reg) - 32'(rem_quo_reg) * DEPTH_32;

    assign sm_we = (state_reg == ST_WRITE) && (cmd_reg.opcode == OP_WRSAMP);
    assign dm_we = (state_reg == ST_WRITE) && (cmd_reg.opcode == OP_WRDESC) && cmd_reg.sound_ok;

    assign rnd  = acc_reg + RND_HALF;
    assign qv   = $signed(rnd[ACC_W-1:32]);
    assign q_hi = (qv > Q_MAX);
    assign q_lo = (qv < Q_MIN);
    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.opcode)
                        OP_TICK:   state_next = ST_TICK;
                        OP_PLAY:   state_next = ST_PLAY;
                        OP_WRSAMP: state_next = ST_REM;
                        OP_WRDESC: state_next = ST_REM;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PLAY:  state_next = ST_IDLE;
            ST_REM:
            begin
                if (rem_cnt_reg == 1'b1)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_IDLE;
            ST_TICK:
            begin
                if (tick_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vaddr_mem[vm_waddr] <= (state_reg == ST_PLAY) ? drd_start_reg : vm_waddr_next_addr;
            vcur_mem[vm_waddr]  <= vm_wcur;
            vend_mem[vm_waddr]  <= vm_wend;
            vgain_mem[vm_waddr] <= vm_wgain;
        end
        vrd_addr_reg <= vaddr_mem[vm_raddr];
        vrd_cur_reg  <= vcur_mem[vm_raddr];
        vrd_end_reg  <= vend_mem[vm_raddr];
        vrd_gain_reg <= vgain_mem[vm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            smem[rem_reg] <= cmd_reg.sample;
        end
        srd_reg <= smem[vrd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dstart_mem[c_sidx] <= rem_reg;
            dlen_mem[c_sidx]   <= cmd_reg.length;
        end
        drd_start_reg <= dstart_mem[q_sidx];
        drd_len_reg   <= dlen_mem[q_sidx];
        drd_vld_reg   <= dvld_reg[q_sidx];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg   <= q_cmd;
            rem_x_reg <= q_cmd.address;
        end
        // quotient registered from rem_x_reg, remainder from the registered quotient
        rem_quo_reg <= rem_prod[38:32];
        rem_reg     <= ADDR_W'(rem_diff);
        p1_idx_reg  <= vm_raddr;
        p2_gain_reg <= vrd_gain_reg;
        prod1_reg   <= P1_W'($signed(srd_reg)) * P1_W'($signed({1'b0, p2_gain_reg}));
        prod2_reg   <= P2_W'(prod1_reg) * P2_W'($signed({1'b0, master_reg}));
        if (fin_go)
        begin
            mixed_reg <= q_hi ? MIX_MAX : (q_lo ? MIX_MIN : qv[15:0]);
            sat_reg   <= q_hi || q_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            master_reg    <= UNITY_GAIN;
            active_reg    <= '0;
            dvld_reg      <= '0;
            rem_cnt_reg   <= 1'b0;
            iss_cnt_reg   <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            p3_vld_reg    <= 1'b0;
            p4_vld_reg    <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                master_reg <= clamp_gain(cfg_data);
            end
            if (play_go)
            begin
                active_reg[free_idx] <= 1'b1;
            end
            else if (p1_act && !p1_play)
            begin
                active_reg[p1_idx_reg] <= 1'b0;
            end
            if (dm_we)
            begin
                dvld_reg[c_sidx] <= 1'b1;
            end
            if (q_pop)
            begin
                rem_cnt_reg <= 1'b0;
            end
            else if (state_reg == ST_REM)
            begin
                rem_cnt_reg <= rem_cnt_reg + 1'b1;
            end
            if (q_pop)
            begin
                iss_cnt_reg <= '0;
                acc_reg     <= '0;
            end
            else
            begin
                if (tick_issue)
                begin
                    iss_cnt_reg <= iss_cnt_reg + 1'b1;
                end
                if (p4_vld_reg)
                begin
                    acc_reg <= acc_reg + ACC_W'(prod2_reg);
                end
            end
            p1_vld_reg <= tick_issue;
            p2_vld_reg <= p1_play;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_reg;
    assign saturated    = sat_reg;

endmodule

// ----- rtl/polyphonic_sample_mixer.sv -----
// Top level: a tick item's frame comes from the voice walk (one voice per cycle) through
// the 4-stage multiply/accumulate pipe, rounded and clipped into the result register.
// The back end takes one queued item at a time; a tick waits for a free result register.
// A 4-item queue and a result register decouple both channels; config is always ready.
// Reset clears voice activity, descriptor valid bits and master volume (unity);
// sample memory is not initialized.

module polyphonic_sample_mixer import psm_pkg::*;
#(
    parameter int NUM_VOICES   = DEF_NUM_VOICES,
    parameter int NUM_SOUNDS   = DEF_NUM_SOUNDS,
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [2:0]         sound_id,
    input  logic [16:0]        play_volume,
    input  logic [15:0]        address,
    input  logic signed [15:0] sample_value,
    input  logic [16:0]        sound_length,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [16:0]        master_volume,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] mixed_sample,
    output logic               saturated
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    psm_front #(
        .NUM_SOUNDS (NUM_SOUNDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .sound_id     (sound_id),
        .play_volume  (play_volume),
        .address      (address),
        .sample_value (sample_value),
        .sound_length (sound_length),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop)
    );

    psm_back #(
        .NUM_VOICES   (NUM_VOICES),
        .NUM_SOUNDS   (NUM_SOUNDS),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (master_volume),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_sample (mixed_sample),
        .saturated    (saturated)
    );

endmodule

// ----- rtl/psm_checker.sv -----
// psm_checker: port-level assertions for polyphonic_sample_mixer, attached by bind.
// Depends on psm_pkg.

module psm_checker import psm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         opcode,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] mixed_sample,
    input logic               saturated
);

    logic [3:0] pend_reg;
    logic       tick_in;
    logic       frame_out;

    assign tick_in   = in_valid && in_ready && (opcode == OP_TICK);
    assign frame_out = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (tick_in && !frame_out)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (!tick_in && frame_out)
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mixed_sample) && $stable(saturated))
        else $error("stalled frame changed");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> mixed_sample == MIX_MAX || mixed_sample == MIX_MIN)
        else $error("clip flag without rail value");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("frame without a tick item");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 4'(QUEUE_DEPTH + 2))
        else $error("more ticks in flight than storage allows");

endmodule

bind polyphonic_sample_mixer psm_checker u_psm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mixed_sample (mixed_sample),
    .saturated    (saturated)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for polyphonic_sample_mixer: directed and random item traffic with
// an item-level mixer predictor and per-field frame comparison. Depends on rtl/psm_pkg.sv
// and rtl/polyphonic_sample_mixer.sv.

module testbench;
    import psm_pkg::*;

    localparam int VOICES       = DEF_NUM_VOICES;
    localparam int SOUNDS       = DEF_NUM_SOUNDS;
    localparam int QUIET_CYCLES = 150;
    localparam int LIMIT_CYCLES = 600000;
    localparam logic [15:0] POOL_BASE  = 16'hFFE0;
    localparam int          POOL_WORDS = 160;

    typedef struct {
        logic [1:0]         op;
        logic [2:0]         id;
        logic [16:0]        vol;
        logic [15:0]        addr;
        logic signed [15:0] smp;
        logic [16:0]        len;
    } mixer_item_t;

    typedef struct {
        logic signed [15:0] mix;
        logic               sat;
    } mix_frame_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode        = OP_TICK;
    logic [2:0]         sound_id      = '0;
    logic [16:0]        play_volume   = '0;
    logic [15:0]        address       = '0;
    logic signed [15:0] sample_value  = '0;
    logic [16:0]        sound_length  = '0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [16:0]        master_volume = UNITY_GAIN;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic signed [15:0] mixed_sample;
    logic               saturated;

    // predictor state
    logic [16:0]        master_gain;
    bit                 voice_on   [VOICES];
    logic [15:0]        voice_base [VOICES];
    logic [16:0]        voice_pos  [VOICES];
    logic [16:0]        voice_len  [VOICES];
    logic [16:0]        voice_gain [VOICES];
    logic [15:0]        snd_base   [SOUNDS];
    logic [16:0]        snd_len    [SOUNDS];
    logic signed [15:0] sample_ram  [0:65535];
    bit                 loaded_word [0:65535];

    mix_frame_t pending_frames[$];

    bit calm = 1'b0;
    int fault_count    = 0;
    int items_sent     = 0;
    int frames_checked = 0;
    int clipped_frames = 0;
    int plays_dropped  = 0;
    int master_writes  = 0;
    int cycle_count    = 0;

    polyphonic_sample_mixer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .sound_id      (sound_id),
        .play_volume   (play_volume),
        .address       (address),
        .sample_value  (sample_value),
        .sound_length  (sound_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .master_volume (master_volume),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mixed_sample  (mixed_sample),
        .saturated     (saturated)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("polyphonic_sample_mixer verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("frame with nothing pending: mixed_sample %0d saturated %0b",
                       mixed_sample, saturated);
                fault_count++;
            end
            else
            begin
                if (mixed_sample !== pending_frames[0].mix)
                begin
                    $error("mixed_sample: expected %0d, actual %0d",
                           pending_frames[0].mix, mixed_sample);
                    fault_count++;
                end
                if (saturated !== pending_frames[0].sat)
                begin
                    $error("saturated: expected %0b, actual %0b",
                           pending_frames[0].sat, saturated);
                    fault_count++;
                end
                if (pending_frames[0].sat)
                    clipped_frames++;
                pending_frames.delete(0);
                frames_checked++;
            end
        end
    end

    function automatic logic [16:0] limit_to_unity(input logic [16:0] g);
        return (g > UNITY_GAIN) ? UNITY_GAIN : g;
    endfunction

    // every word a sound would read has been written
    function automatic bit sound_is_loaded(input logic [2:0] id);
        logic [15:0] a;
        for (int i = 0; i < int'(snd_len[id]); i++)
        begin
            a = snd_base[id] + 16'(i);
            if (!loaded_word[a])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void advance_mixer_state(input mixer_item_t it);
        longint      acc;
        longint      rounded;
        logic [15:0] a;
        mix_frame_t  f;
        bit          placed;
        case (it.op)
            OP_TICK:
            begin
                acc = 0;
                for (int v = 0; v < VOICES; v++)
                begin
                    if (voice_on[v])
                    begin
                        if (voice_pos[v] >= voice_len[v])
                            voice_on[v] = 1'b0;
                        else
                        begin
                            a = voice_base[v] + voice_pos[v][15:0];
                            acc += longint'(sample_ram[a]) * longint'(voice_gain[v])
                                   * longint'(master_gain);
                            voice_pos[v] = voice_pos[v] + 17'd1;
                        end
                    end
                end
                rounded = (acc + 64'sd2147483648) >>> 32;
                f.sat = 1'b1;
                if (rounded > 32767)
                    f.mix = MIX_MAX;
                else if (rounded < -32768)
                    f.mix = MIX_MIN;
                else
                begin
                    f.mix = 16'(rounded);
                    f.sat = 1'b0;
                end
                pending_frames.push_back(f);
            end
            OP_PLAY:
            begin
                placed = 1'b0;
                if (snd_len[it.id] != 0)
                begin
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (!placed && !voice_on[v])
                        begin
                            voice_on[v]   = 1'b1;
                            voice_base[v] = snd_base[it.id];
                            voice_len[v]  = snd_len[it.id];
                            voice_pos[v]  = '0;
                            voice_gain[v] = limit_to_unity(it.vol);
                            placed = 1'b1;
                        end
                    end
                end
                if (!placed)
                    plays_dropped++;
            end
            OP_WRSAMP:
            begin
                sample_ram[it.addr]  = it.smp;
                loaded_word[it.addr] = 1'b1;
            end
            OP_WRDESC:
            begin
                snd_base[it.id] = it.addr;
                snd_len[it.id]  = it.len;
            end
        endcase
    endfunction

    function automatic mixer_item_t scrambled_item();
        mixer_item_t it;
        it.op   = 2'($urandom);
        it.id   = 3'($urandom);
        it.vol  = 17'($urandom);
        it.addr = 16'($urandom);
        it.smp  = 16'($urandom);
        it.len  = 17'($urandom);
        return it;
    endfunction

    function automatic mixer_item_t random_item();
        mixer_item_t it;
        int          pick;
        int          k;
        it = scrambled_item();
        pick = $urandom_range(99);
        if (pick < 40)
            it.op = OP_TICK;
        else if (pick < 65)
        begin
            it.op = OP_PLAY;
            case ($urandom_range(9))
                0: it.vol = '0;
                1: it.vol = UNITY_GAIN;
                2: it.vol = 17'($urandom_range(65537, 131071));
                default: it.vol = 17'($urandom_range(0, 65536));
            endcase
            if (snd_len[it.id] != 0 && !sound_is_loaded(it.id))
                it.op = OP_TICK;
        end
        else if (pick < 85)
        begin
            it.op = OP_WRSAMP;
            if ($urandom_range(99) < 85)
                it.addr = POOL_BASE + 16'($urandom_range(0, POOL_WORDS - 1));
            if ($urandom_range(9) == 0)
                it.smp = $urandom_range(1) ? MIX_MAX : MIX_MIN;
        end
        else
        begin
            it.op = OP_WRDESC;
            pick = $urandom_range(9);
            if (pick == 0)
                it.len = '0;
            else if (pick > 1)
            begin
                k = $urandom_range(0, POOL_WORDS - 1);
                it.len  = 17'($urandom_range(1, (POOL_WORDS - k < 24) ? POOL_WORDS - k : 24));
                it.addr = POOL_BASE + 16'(k);
            end
        end
        return it;
    endfunction

    task automatic send_item(input mixer_item_t it);
        if (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= it.op;
        sound_id     <= it.id;
        play_volume  <= it.vol;
        address      <= it.addr;
        sample_value <= it.smp;
        sound_length <= it.len;
        do @(posedge clk); while (!in_ready);
        advance_mixer_state(it);
        items_sent++;
    endtask

    task automatic send_tick();
        mixer_item_t it;
        it = scrambled_item();
        it.op = OP_TICK;
        send_item(it);
    endtask

    task automatic send_play(input logic [2:0] id, input logic [16:0] vol);
        mixer_item_t it;
        it = scrambled_item();
        it.op  = OP_PLAY;
        it.id  = id;
        it.vol = vol;
        send_item(it);
    endtask

    task automatic send_sample(input logic [15:0] addr, input logic signed [15:0] val);
        mixer_item_t it;
        it = scrambled_item();
        it.op   = OP_WRSAMP;
        it.addr = addr;
        it.smp  = val;
        send_item(it);
    endtask

    task automatic send_sound(input logic [2:0] id, input logic [15:0] start,
                              input logic [16:0] len);
        mixer_item_t it;
        it = scrambled_item();
        it.op   = OP_WRDESC;
        it.id   = id;
        it.addr = start;
        it.len  = len;
        send_item(it);
    endtask

    // drain all frames, then let queued writes retire
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_master(input logic [16:0] gain);
        settle_block();
        cfg_valid     <= 1'b1;
        master_volume <= gain;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        master_gain  = limit_to_unity(gain);
        master_writes++;
    endtask

    task automatic test_idle_output();
        send_tick();
        send_play(3'd3, UNITY_GAIN);
        send_tick();
    endtask

    task automatic load_sample_pool();
        for (int i = 0; i < POOL_WORDS; i++)
            send_sample(POOL_BASE + 16'(i), 16'($urandom));
    endtask

    // +/- half LSB products: ties round toward plus infinity
    task automatic test_rounding();
        send_sample(16'h0010, 16'sd1);
        send_sample(16'h0011, -16'sd1);
        send_sound(3'd0, 16'h0010, 17'd2);
        send_play(3'd0, 17'd32768);
        repeat (3) send_tick();
    endtask

    task automatic test_saturation();
        send_sample(16'h0020, MIX_MAX);
        send_sample(16'h0021, MIX_MIN);
        send_sound(3'd1, 16'h0020, 17'd2);
        send_play(3'd1, 17'h1FFFF);
        send_play(3'd1, UNITY_GAIN);
        repeat (3) send_tick();
    endtask

    task automatic test_wrap_and_empty();
        send_sound(3'd7, 16'hFFFF, 17'd2);
        send_play(3'd7, 17'd0);
        send_play(3'd7, 17'd20000);
        send_sound(3'd2, 16'h0000, 17'd0);
        send_play(3'd2, UNITY_GAIN);
        send_sound(3'd5, 16'($urandom), 17'h1FFFF);
        repeat (3) send_tick();
    endtask

    task automatic test_voice_exhaustion();
        send_sound(3'd6, POOL_BASE + 16'($urandom_range(0, POOL_WORDS - 40)), 17'd40);
        repeat (VOICES + 1) send_play(3'd6, 17'($urandom_range(0, 65536)));
        repeat (3) send_tick();
    endtask

    task automatic run_traffic_phase(input logic [16:0] gain, input int count,
                                     input bit no_idle);
        write_master(gain);
        calm = no_idle;
        repeat (count) send_item(random_item());
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(UNITY_GAIN, 100, 1'b0);
        test_voice_exhaustion();
        run_traffic_phase(17'h1FFFF, 100, 1'b1);
        test_voice_exhaustion();
        run_traffic_phase(17'($urandom_range(1, 65535)), 150, 1'b0);
        run_traffic_phase(17'd0, 40, 1'b0);
        run_traffic_phase(17'($urandom_range(65537, 131070)), 40, 1'b0);
        run_traffic_phase(17'($urandom_range(0, 65536)), 100, 1'b0);
    endtask

    initial
    begin
        master_gain = UNITY_GAIN;
        for (int v = 0; v < VOICES; v++)
        begin
            voice_on[v]   = 1'b0;
            voice_base[v] = '0;
            voice_pos[v]  = '0;
            voice_len[v]  = '0;
            voice_gain[v] = '0;
        end
        for (int s = 0; s < SOUNDS; s++)
        begin
            snd_base[s] = '0;
            snd_len[s]  = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_output();
        load_sample_pool();
        test_rounding();
        test_saturation();
        test_wrap_and_empty();
        test_random_traffic();

        settle_block();
        $display("Sent %0d items; %0d frames compared, %0d clipped, %0d plays dropped.",
                 items_sent, frames_checked, clipped_frames, plays_dropped);
        $display("Master gain written %0d times, zero and above-unity values included.",
                 master_writes);
        if (fault_count == 0 && pending_frames.size() == 0)
            $display("polyphonic_sample_mixer verification clean");
        else
            $display("polyphonic_sample_mixer verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/psm_pkg.sv
rtl/psm_front.sv
rtl/psm_back.sv
rtl/polyphonic_sample_mixer.sv
rtl/psm_checker.sv
verif/testbench.sv
